// ===== rtl/bbt_pkg.sv =====
// Shared types and constants of the buffer bounds table.
`default_nettype none

package bbt_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned SizeW = 32;
  localparam int unsigned EndW  = AddrW + 1;
  localparam int unsigned DefaultMaxEntries = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RESIZE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // One stored region, size in the upper bits and base in the lower bits.
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] base;
  } region_t;

  // Outcome of one range check.
  typedef struct packed {
    logic            hit;
    logic [EndW-1:0] end_addr;
  } range_res_t;

endpackage

`default_nettype wire

// ===== rtl/buffer_bounds_table_unit.sv =====
// Top level of the buffer bounds table: sequencer, counters and result register.
// Insert: no slots are walked; the result is registered once the result register is free.
// Query, clear, resize: the sequencer walks the region store one slot per cycle,
// over 1 to entries used slots (0 for an empty table), before the result is registered.
// A new input transaction is taken in the cycle after a result is registered.
// Reset (rst_ni low, asynchronous) empties the table and drops any pending result;
// the region store itself is not cleared and needs no clearing pass.
`default_nettype none

module buffer_bounds_table_unit #(
  parameter int unsigned MaxEntries = bbt_pkg::DefaultMaxEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // [47:0] addr, [79:48] size_bytes
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] func
  // Result channel.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] remaining
  output logic [2:0]       m_axis_tuser   // [0] found, [2:1] status
);

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [CntW-1:0]             used_q, used_d;
  logic [IdxW-1:0]             cur_q, cur_d;
  logic                        hit_q, hit_d;
  bbt_pkg::func_e              op_q;
  logic [bbt_pkg::AddrW-1:0]   addr_q;
  logic [bbt_pkg::SizeW-1:0]   size_q;
  logic [bbt_pkg::AddrW-1:0]   base_q;
  logic [bbt_pkg::SizeW-1:0]   end_lo_q;

  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q;
  logic [bbt_pkg::SizeW-1:0]   out_rem_q;
  bbt_pkg::status_e            out_status_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        done_fire;
  logic                        full;
  logic                        last_slot;

  logic                        mem_we;
  logic [IdxW-1:0]             mem_waddr;
  bbt_pkg::region_t            mem_wdata;
  logic [IdxW-1:0]             mem_raddr;
  bbt_pkg::region_t            mem_rdata;
  bbt_pkg::range_res_t         range_res;

  logic                        res_found;
  logic [bbt_pkg::SizeW-1:0]   res_rem;
  bbt_pkg::status_e            res_status;

  // The sequencer takes a transaction only when it is idle. The result register
  // is separate, so a finished result may wait while the next item is taken.
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign done_fire     = (state_q == StDone) && out_free;

  assign full      = (used_q == CntW'(MaxEntries));
  assign last_slot = ((CntW'(cur_q) + CntW'(1)) == used_q);

  // The store is read one slot ahead: while the checker looks at the slot in
  // cur_q, the read of the following slot is already under way.
  always_comb begin
    if (state_q == StScan && !last_slot) begin
      mem_raddr = cur_q + IdxW'(1);
    end else if (state_q == StScan) begin
      mem_raddr = cur_q;
    end else begin
      mem_raddr = '0;
    end
  end

  bbt_region_mem #(
    .Depth (MaxEntries),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bbt_range_unit u_range (
    .base_i  (mem_rdata.base),
    .size_i  (mem_rdata.size),
    .probe_i (addr_q),
    .res_o   (range_res)
  );

  // Table updates all happen as the result is handed to the result register.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = '{size: size_q, base: base_q};
    if (done_fire) begin
      case (op_q)
        bbt_pkg::OP_INSERT: begin
          mem_we    = !full;
          mem_waddr = used_q[IdxW-1:0];
          mem_wdata = '{size: size_q, base: addr_q};
        end
        bbt_pkg::OP_CLEAR: begin
          mem_we    = hit_q;
          mem_wdata = '0;
        end
        bbt_pkg::OP_RESIZE: begin
          mem_we    = hit_q;
        end
        default: begin
          mem_we    = 1'b0;
        end
      endcase
    end
  end

  // Result of the item in flight.
  always_comb begin
    res_found  = 1'b0;
    res_rem    = '0;
    res_status = bbt_pkg::ST_OK;
    if (op_q == bbt_pkg::OP_INSERT) begin
      res_status = full ? bbt_pkg::ST_FULL : bbt_pkg::ST_OK;
    end else if (hit_q) begin
      res_found = 1'b1;
      // The end never lies below the probe on a hit, so the low bits suffice.
      if (op_q == bbt_pkg::OP_QUERY) begin
        res_rem = end_lo_q - addr_q[bbt_pkg::SizeW-1:0];
      end
    end else begin
      res_status = bbt_pkg::ST_NO_MATCH;
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cur_d       = cur_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          cur_d = '0;
          hit_d = 1'b0;
          if (bbt_pkg::func_e'(s_axis_tuser) == bbt_pkg::OP_INSERT || used_q == '0) begin
            state_d = StDone;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (range_res.hit) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else if (last_slot) begin
          state_d = StDone;
        end else begin
          cur_d = cur_q + IdxW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (op_q == bbt_pkg::OP_INSERT && !full) begin
            used_d = used_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      cur_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cur_q       <= cur_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= bbt_pkg::func_e'(s_axis_tuser);
      addr_q <= s_axis_tdata[47:0];
      size_q <= s_axis_tdata[79:48];
    end
    if (state_q == StScan && range_res.hit) begin
      base_q   <= mem_rdata.base;
      end_lo_q <= range_res.end_addr[bbt_pkg::SizeW-1:0];
    end
    if (done_fire) begin
      out_found_q  <= res_found;
      out_rem_q    <= res_rem;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rem_q;
  assign m_axis_tuser  = {out_status_q, out_found_q};

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MaxEntries))
    else $error("entry count above table depth");

  // The walk only visits slots that are in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CntW'(cur_q) < used_q))
    else $error("scan beyond used entries");

  // A stored insert grows the table by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && op_q == bbt_pkg::OP_INSERT && !full) |=>
      (used_q == $past(used_q) + CntW'(1)))
    else $error("insert did not advance entry count");

  // A hit is only ever reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == bbt_pkg::ST_OK))
    else $error("hit reported with error status");

  // Only a query hit carries a nonzero remaining count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && !(op_q == bbt_pkg::OP_QUERY && hit_q)) |=> (m_axis_tdata == '0))
    else $error("remaining set on a non-query result");

endmodule

`default_nettype wire

// ===== rtl/bbt_region_mem.sv =====
// Region store: one write port and one registered read port.
`default_nettype none

module bbt_region_mem #(
  parameter int unsigned Depth = bbt_pkg::DefaultMaxEntries,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IdxW-1:0]   waddr_i,
  input  wire bbt_pkg::region_t  wdata_i,
  input  wire logic [IdxW-1:0]   raddr_i,
  output bbt_pkg::region_t       rdata_o
);

  bbt_pkg::region_t mem [Depth];
  bbt_pkg::region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bbt_range_unit.sv =====
// Shared range checker: forms the inclusive end of a region and tests a probe.
`default_nettype none

module bbt_range_unit (
  input  wire logic [bbt_pkg::AddrW-1:0] base_i,
  input  wire logic [bbt_pkg::SizeW-1:0] size_i,
  input  wire logic [bbt_pkg::AddrW-1:0] probe_i,
  output bbt_pkg::range_res_t            res_o
);

  logic [bbt_pkg::EndW-1:0] base_ext;
  logic [bbt_pkg::EndW-1:0] probe_ext;
  logic [bbt_pkg::EndW-1:0] end_addr;

  // The end is formed one bit wider than an address so it never wraps.
  assign base_ext  = {1'b0, base_i};
  assign probe_ext = {1'b0, probe_i};
  assign end_addr  = base_ext + {{(bbt_pkg::EndW - bbt_pkg::SizeW){1'b0}}, size_i};

  assign res_o.end_addr = end_addr;
  assign res_o.hit      = (base_ext <= probe_ext) && (probe_ext <= end_addr);

endmodule

`default_nettype wire

// ===== verif/bbt_result_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the buffer bounds table and compares every result it returns.
module bbt_result_checker
  import bbt_pkg::*;
#(
  parameter int unsigned MaxEntries = DefaultMaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [79:0] in_data_i,   // [47:0] addr, [79:48] size_bytes
  input  logic [1:0]  in_user_i,   // [1:0] func
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,  // [31:0] remaining
  input  logic [2:0]  out_user_i,  // [0] found, [2:1] status
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic             found;
    logic [SizeW-1:0] remaining;
    status_e          status;
  } lookup_result_t;

  logic [AddrW-1:0] tbl_base [MaxEntries];
  logic [SizeW-1:0] tbl_size [MaxEntries];
  int unsigned      tbl_used;
  lookup_result_t   expected_results [$];
  int               errors = 0;

  // Applies one operation to the table copy and returns the result it must produce.
  // The region end is formed one bit wider than an address, so it never wraps.
  function automatic lookup_result_t apply_table_op(func_e op, logic [AddrW-1:0] addr,
                                                    logic [SizeW-1:0] size);
    lookup_result_t  res;
    logic [EndW-1:0] hi;
    logic [EndW-1:0] hit_end;
    int              slot;
    res.found     = 1'b0;
    res.remaining = '0;
    res.status    = ST_OK;
    slot          = -1;
    hit_end       = '0;
    if (op == OP_INSERT) begin
      if (tbl_used < MaxEntries) begin
        tbl_base[tbl_used] = addr;
        tbl_size[tbl_used] = size;
        tbl_used++;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      for (int i = 0; i < int'(tbl_used); i++) begin
        hi = {1'b0, tbl_base[i]} + {17'b0, tbl_size[i]};
        if (slot < 0 && tbl_base[i] <= addr && {1'b0, addr} <= hi) begin
          slot    = i;
          hit_end = hi;
        end
      end
      if (slot < 0) begin
        res.status = ST_NO_MATCH;
      end else begin
        res.found = 1'b1;
        case (op)
          OP_QUERY: begin
            hi            = hit_end - {1'b0, addr};
            res.remaining = hi[SizeW-1:0];
          end
          OP_CLEAR: begin
            tbl_base[slot] = '0;
            tbl_size[slot] = '0;
          end
          default: begin
            tbl_size[slot] = size;
          end
        endcase
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_ni) begin
      tbl_used = 0;
      expected_results.delete();
      err_count_o <= errors;
      pending_o   <= 0;
    end else begin
      // Results are checked before the new input is predicted, so a result and an
      // input in the same cycle always meet the queue in its old order.
      if (out_valid_i && out_ready_i) begin
        got.found     = out_user_i[0];
        got.remaining = out_data_i;
        got.status    = status_e'(out_user_i[2:1]);
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: found %0b remaining %0h status %0d",
                   $time, got.found, got.remaining, got.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, got.found);
            errors++;
          end
          if (got.remaining !== want.remaining) begin
            $display("%0t: remaining mismatch: expected %0h, actual %0h",
                     $time, want.remaining, got.remaining);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_table_op(func_e'(in_user_i), in_data_i[47:0],
                                                  in_data_i[79:48]));
      end
      err_count_o <= errors;
      pending_o   <= expected_results.size();
    end
  end

endmodule

// ===== verif/buffer_bounds_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top that drives the buffer bounds table, stalls its results and gives the verdict.
module buffer_bounds_table_unit_tb;
  import bbt_pkg::*;

  localparam int unsigned NumRandomItems = 600;
  localparam int unsigned MaxGap         = 12;
  // A lookup walks at most every slot once.
  localparam int unsigned DrainCycles    = 100;
  // The slowest correct spacing between two transactions is well under the watchdog limit.
  localparam int unsigned WatchdogLimit  = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // [47:0] addr, [79:48] size_bytes
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] remaining
  logic [2:0]  m_axis_tuser;   // [0] found, [2:1] status

  int          err_count;
  int          pending;
  int          idle_cycles = 0;
  // When set, neither side inserts gaps, so back-to-back transactions get exercised.
  bit          no_idle = 1'b0;

  // Regions handed to the block by insert transactions. They only steer the probe
  // addresses toward real hits; clears and resizes are not tracked here.
  logic [AddrW-1:0] known_base [$];
  logic [SizeW-1:0] known_size [$];

  always #1 clk_i = ~clk_i;

  buffer_bounds_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bbt_result_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[AddrW-1:0];
  endfunction

  // Presents one transaction on the input channel and returns at the edge where it
  // is accepted. Valid is left high there; the next call either keeps it high for a
  // back-to-back transaction or lowers it for a gap, so each edge sees one update.
  task automatic send_item(func_e op, logic [AddrW-1:0] addr, logic [SizeW-1:0] size);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {size, addr};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_INSERT && known_base.size() < DefaultMaxEntries) begin
      known_base.push_back(addr);
      known_size.push_back(size);
    end
  endtask

  // Directed part: empty table, address extremes, the inclusive end at the top of
  // the address space, overlapping regions, resize to zero and cleared slots that
  // still match address zero.
  task automatic run_directed();
    send_item(OP_QUERY,  '0, '0);
    send_item(OP_CLEAR,  '1, '1);
    send_item(OP_RESIZE, 48'h0000_0000_1234, 32'hFFFF_FFFF);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_QUERY,  '0, 32'hFFFF_FFFF);
    send_item(OP_QUERY,  48'h1, '0);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_QUERY,  '1, '0);
    send_item(OP_QUERY,  48'hFFFF_FFFF_FFFE, '0);
    send_item(OP_INSERT, 48'h1000, 32'h100);
    send_item(OP_INSERT, 48'h1080, 32'h200);
    send_item(OP_QUERY,  48'h10C0, '0);
    send_item(OP_QUERY,  48'h1100, '0);
    send_item(OP_QUERY,  48'h1101, '0);
    send_item(OP_QUERY,  48'h0FFF, '0);
    send_item(OP_RESIZE, 48'h1000, '0);
    send_item(OP_QUERY,  48'h1000, '0);
    send_item(OP_QUERY,  48'h1001, '0);
    send_item(OP_CLEAR,  48'h1080, '1);
    send_item(OP_QUERY,  48'h1080, '0);
    send_item(OP_CLEAR,  '0, '0);
    send_item(OP_QUERY,  '0, '0);
    send_item(OP_RESIZE, '0, 32'hFFFF_FFFF);
    send_item(OP_QUERY,  48'hFFFF_FFFF, '0);
  endtask

  // Random part. About one transaction in five is an insert, so the table fills
  // part of the way through and the later inserts report a full table. The other
  // operations mostly probe a known region at its base, its inclusive end, just
  // outside it or somewhere inside, or address zero; the rest probe random addresses.
  task automatic run_random();
    int unsigned      pick;
    int unsigned      idx;
    longint unsigned  span;
    logic [EndW-1:0]  hi;
    func_e            op;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    for (int n = 0; n < int'(NumRandomItems); n++) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      addr = rand_addr();
      size = $urandom;
      if (pick < 20) begin
        op = OP_INSERT;
        case ($urandom_range(0, 5))
          0, 1: begin
            // Small regions packed near zero overlap one another often.
            addr = AddrW'($urandom_range(0, 65535));
            size = $urandom_range(0, 4096);
          end
          2: begin
            // Near the top, so the region end spills past the address width.
            addr = '1 - AddrW'($urandom_range(0, 1 << 20));
          end
          3: size = $urandom_range(0, 1) ? '1 : '0;
          4: size = $urandom_range(0, 255);
          default: ;
        endcase
      end else begin
        if (pick < 65) begin
          op = OP_QUERY;
        end else if (pick < 75) begin
          op = OP_CLEAR;
        end else begin
          op = OP_RESIZE;
          case ($urandom_range(0, 5))
            0: size = '0;
            1: size = '1;
            2: size = $urandom_range(0, 4096);
            default: ;
          endcase
        end
        if (known_base.size() != 0 && $urandom_range(0, 99) < 75) begin
          idx = $urandom_range(0, known_base.size() - 1);
          hi  = {1'b0, known_base[idx]} + {17'b0, known_size[idx]};
          case ($urandom_range(0, 6))
            0: addr = known_base[idx];
            1: addr = hi[AddrW-1:0];
            2: addr = hi[AddrW-1:0] + 1'b1;
            3: addr = known_base[idx] - 1'b1;
            4: addr = '0;
            default: begin
              span = 64'(known_size[idx]) + 64'd1;
              addr = known_base[idx] + AddrW'(64'($urandom) % span);
            end
          endcase
        end
      end
      send_item(op, addr, size);
    end
  endtask

  // Result side: a fresh stall is drawn for every result, then ready stays high
  // until one is taken.
  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Ends the run when no transaction has been accepted on either channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= int'(WatchdogLimit)) begin
      $display("[buffer_bounds_table_unit] ERROR");
      $finish;
    end
  end

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_INSERT;
    rst_ni        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    // The checker keeps a registered count of the results still pending.
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("[buffer_bounds_table_unit] OK");
    end else begin
      $display("[buffer_bounds_table_unit] ERROR");
    end
    $finish;
  end

endmodule
